>>> rtl/core/flvtd_pkg.sv
// shared constants and the script prefix table for the flv tag deframer
package flvtd_pkg;

	localparam int unsigned SIZE_W  = 25;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned SID_W   = 32;
	localparam int unsigned HCNT_W  = 4;

	localparam logic [7:0] FILE_MAGIC  = 8'h46;
	localparam logic [7:0] TYPE_SCRIPT = 8'h12;

	localparam logic [HCNT_W-1:0] FILE_HDR_LEN = 4'd13;
	localparam logic [HCNT_W-1:0] TAG_HDR_LAST = 4'd10;
	localparam logic [HCNT_W-1:0] TRAIL_LEN    = 4'd4;
	localparam logic [HCNT_W-1:0] PREFIX_LAST  = 4'd15;

	localparam logic [SIZE_W-1:0] PREFIX_LEN = 25'd16;

	// amf string "@setDataFrame" with its type marker and length
	function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
		logic [7:0] b;
		begin
			case (idx)
				4'd0:    b = 8'h02;
				4'd1:    b = 8'h00;
				4'd2:    b = 8'h0D;
				4'd3:    b = 8'h40;
				4'd4:    b = 8'h73;
				4'd5:    b = 8'h65;
				4'd6:    b = 8'h74;
				4'd7:    b = 8'h44;
				4'd8:    b = 8'h61;
				4'd9:    b = 8'h74;
				4'd10:   b = 8'h61;
				4'd11:   b = 8'h46;
				4'd12:   b = 8'h72;
				4'd13:   b = 8'h61;
				4'd14:   b = 8'h6D;
				4'd15:   b = 8'h65;
				default: b = 8'h00;
			endcase
			return b;
		end
	endfunction

endpackage

>>> rtl/core/flv_tag_to_packet_deframer_unit.sv
// flv tag deframer: byte stream in, packet body words out
// timing: a body byte is registered and shows on the output in the cycle after it is accepted
// throughput: one byte per cycle; a script tag header adds a 16-word prefix burst from the
//   output register; the input is held off during the burst and while an output word stalls
// reset: arst_n clears the parser to tag start, all header fields and stream_id to zero
// no memories, no clearing pass after reset
module flv_tag_to_packet_deframer_unit
	import flvtd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// config write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,       // stream_id
	// input byte stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	// packet word stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // out_byte, body_size, time_stamp, packet_stream, zero pad
	output logic [8:0]   m_axis_tuser,   // byte_valid, packet_type
	output logic         m_axis_tlast    // last
);

	typedef enum logic [2:0] {
		ST_START,
		ST_FILE,
		ST_HDR,
		ST_BODY,
		ST_TRAIL
	} phase_t;

	// parser state
	phase_t              phase_q, phase_n;
	logic [HCNT_W-1:0]   hcnt_q, hcnt_n;
	logic [7:0]          tag_type_q, tag_type_n;
	logic [SIZE_W-1:0]   size_total_q, size_total_n;
	logic [STAMP_W-1:0]  stamp_q, stamp_n;
	logic [SIZE_W-1:0]   bytes_left_q, bytes_left_n;
	logic [SID_W-1:0]    stream_id_q;

	// prefix burst sequencer
	logic                burst_q;
	logic [3:0]          burst_cnt_q;

	// result register
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                byte_valid_q;
	logic                last_q;

	// combinational result of the accepted byte
	logic                res_load;
	logic [7:0]          res_byte;
	logic                res_bvalid;
	logic                res_last;
	logic                burst_start;

	logic                out_free;
	logic                s_acc;

	// output slot can take a new word this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	// header fields on the output come straight from the parser state; they only
	// change when a byte is accepted, which needs the output slot to move
	assign s_axis_tready = out_free && !burst_q;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	assign cfg_ready = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, stream_id_q, stamp_q, size_total_q, out_byte_q};
	assign m_axis_tuser  = {tag_type_q, byte_valid_q};
	assign m_axis_tlast  = last_q;

	// next parser state and result for one accepted byte
	always_comb begin
		logic [HCNT_W-1:0] hc;
		logic              hdr;
		logic [SIZE_W-1:0] bl_dec;
		phase_n      = phase_q;
		hcnt_n       = hcnt_q;
		tag_type_n   = tag_type_q;
		size_total_n = size_total_q;
		stamp_n      = stamp_q;
		bytes_left_n = bytes_left_q;
		res_load     = 1'b0;
		res_byte     = 8'd0;
		res_bvalid   = 1'b0;
		res_last     = 1'b0;
		burst_start  = 1'b0;
		hdr          = 1'b0;
		hc           = hcnt_q;
		bl_dec       = bytes_left_q - 25'd1;
		if (s_acc) begin
			case (phase_q)
				ST_FILE: begin
					// skip the rest of the file header
					hcnt_n = hcnt_q + 4'd1;
					if (hcnt_n >= FILE_HDR_LEN) begin
						phase_n = ST_HDR;
						hcnt_n  = '0;
					end
				end
				ST_HDR: begin
					hdr = 1'b1;
				end
				ST_BODY: begin
					bytes_left_n = bl_dec;
					res_load     = 1'b1;
					res_byte     = s_axis_tdata;
					res_bvalid   = 1'b1;
					res_last     = (bl_dec == '0);
					if (bl_dec == '0) begin
						phase_n = ST_TRAIL;
						hcnt_n  = '0;
					end
				end
				ST_TRAIL: begin
					// previous tag size field, dropped
					hcnt_n = hcnt_q + 4'd1;
					if (hcnt_n >= TRAIL_LEN) begin
						phase_n = ST_START;
						hcnt_n  = '0;
					end
				end
				default: begin
					if (s_axis_tdata == FILE_MAGIC) begin
						phase_n = ST_FILE;
						hcnt_n  = 4'd1;
					end else begin
						phase_n = ST_HDR;
						hdr     = 1'b1;
						hc      = '0;
					end
				end
			endcase
		end

		if (hdr) begin
			case (hc)
				4'd0: begin
					tag_type_n   = s_axis_tdata;
					size_total_n = '0;
					stamp_n      = '0;
				end
				4'd1, 4'd2, 4'd3: begin
					size_total_n = {1'b0, size_total_q[15:0], s_axis_tdata};
				end
				4'd4, 4'd5, 4'd6: begin
					stamp_n = {8'd0, stamp_q[15:0], s_axis_tdata};
				end
				4'd7: begin
					// timestamp extension is the top byte
					stamp_n = {s_axis_tdata, stamp_q[23:0]};
				end
				default: begin
				end
			endcase
			hcnt_n = hc + 4'd1;
			if (hc == TAG_HDR_LAST) begin
				hcnt_n       = '0;
				bytes_left_n = size_total_q;
				if (tag_type_q == TYPE_SCRIPT) begin
					// first prefix word now, the rest from the burst sequencer
					size_total_n = size_total_q + PREFIX_LEN;
					burst_start  = 1'b1;
					res_load     = 1'b1;
					res_byte     = prefix_byte(4'd0);
					res_bvalid   = 1'b1;
					res_last     = 1'b0;
					phase_n      = (size_total_q == '0) ? ST_TRAIL : ST_BODY;
				end else if (size_total_q == '0) begin
					// empty body: one end marker with no byte
					res_load   = 1'b1;
					res_byte   = 8'd0;
					res_bvalid = 1'b0;
					res_last   = 1'b1;
					phase_n    = ST_TRAIL;
				end else begin
					phase_n = ST_BODY;
				end
			end
		end
	end

	// parser state, config register, result register and prefix burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ST_START;
			hcnt_q       <= '0;
			tag_type_q   <= '0;
			size_total_q <= '0;
			stamp_q      <= '0;
			bytes_left_q <= '0;
			stream_id_q  <= '0;
			out_valid_q  <= 1'b0;
			burst_q      <= 1'b0;
			burst_cnt_q  <= '0;
			out_byte_q   <= '0;
			byte_valid_q <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			hcnt_q       <= hcnt_n;
			tag_type_q   <= tag_type_n;
			size_total_q <= size_total_n;
			stamp_q      <= stamp_n;
			bytes_left_q <= bytes_left_n;
			if (cfg_valid && cfg_ready) begin
				stream_id_q <= cfg_data;
			end
			if (out_free) begin
				if (burst_q) begin
					// remaining prefix words; the last one closes an empty script packet
					out_valid_q  <= 1'b1;
					out_byte_q   <= prefix_byte(burst_cnt_q);
					byte_valid_q <= 1'b1;
					last_q       <= (burst_cnt_q == PREFIX_LAST) && (bytes_left_q == '0);
					burst_cnt_q  <= burst_cnt_q + 4'd1;
					if (burst_cnt_q == PREFIX_LAST) begin
						burst_q <= 1'b0;
					end
				end else if (res_load) begin
					out_valid_q  <= 1'b1;
					out_byte_q   <= res_byte;
					byte_valid_q <= res_bvalid;
					last_q       <= res_last;
					if (burst_start) begin
						burst_q     <= 1'b1;
						burst_cnt_q <= 4'd1;
					end
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	// input held off for the whole prefix burst
	a_burst_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> !s_axis_tready)
		else $error("input accepted during script prefix burst");

	// an end marker without a byte always closes its packet
	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
		else $error("empty marker without tlast");

	// every accepted body byte shows up as a word in the next cycle
	a_body_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && phase_q == ST_BODY) |=> (m_axis_tvalid && m_axis_tuser[0]))
		else $error("body byte lost");

	// burst counter idles at zero or runs only inside a burst
	a_burst_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!burst_q && $past(!burst_q)) |-> (burst_cnt_q == '0 || $stable(burst_cnt_q)))
		else $error("burst counter moved outside a burst");
`endif

endmodule
